// ===== hdl/cpst_pkg.sv =====
// shared types and codes for the collision pair state table
// request and response beat structs, fsm states, mode and contact codes
`default_nettype none

package cpst_pkg;

  localparam int DEF_TABLE_ENTRIES = 64;
  localparam int DEF_BUCKET_WAYS   = 4;
  localparam int DEF_ID_BITS       = 16;

  // request modes
  localparam logic [1:0] MODE_TOUCH = 2'd0;
  localparam logic [1:0] MODE_APART = 2'd1;
  localparam logic [1:0] MODE_INVAL = 2'd2;
  localparam logic [1:0] MODE_QUERY = 2'd3;

  // contact states
  localparam logic [2:0] PST_NONE    = 3'd0;
  localparam logic [2:0] PST_START   = 3'd1;
  localparam logic [2:0] PST_PERSIST = 3'd2;
  localparam logic [2:0] PST_END     = 3'd3;
  localparam logic [2:0] PST_INVALID = 3'd4;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] id_a;
    logic [15:0] id_b;
    logic        was_colliding;
  } cpst_req_t;

  typedef struct packed {
    logic [2:0] pair_state;
    logic       found;
    logic       table_full;
  } cpst_rsp_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_READ,
    S_UPDATE
  } cpst_fsm_t;

  function automatic logic [2:0] cpst_new_state(input logic [1:0] mode, input logic was);
    logic [2:0] st;
    case (mode)
      MODE_TOUCH: st = was ? PST_PERSIST : PST_START;
      MODE_APART: st = was ? PST_END : PST_NONE;
      default:    st = PST_INVALID;
    endcase
    return st;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/collision_pair_state_table.sv =====
// collision pair state table: one table row per bucket, every way of a bucket
// in one memory word; depends on cpst_pkg
//
// usage:
//   request channel (req_valid / req_stall / req) carries mode, two ids and the
//   previous-frame collision flag; the response channel (rsp_valid / rsp_stall /
//   rsp) returns one beat per request with pair_state, found and table_full
//   response timing: the response is registered after the accept, hash, row
//   read and update steps; when the bucket count is a power of two the hash
//   step masks the id sum, otherwise the bucket index is a reciprocal-multiply
//   remainder, a quotient step and a remainder step per 16-bit digit of the id sum
//   requests: a new request is taken only once the previous one has passed the
//   accept, hash, row read and row write-back steps on the single table memory
//   reset: the table memory is swept one bucket row per cycle over all
//   TABLE_ENTRIES / BUCKET_WAYS rows (at least one), while req_stall stays high
//   a stalled response holds in the output register; the next request is still
//   taken, and its write-back waits until the output register frees up
`default_nettype none

module collision_pair_state_table
  import cpst_pkg::*;
#(
  parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
  parameter int BUCKET_WAYS   = DEF_BUCKET_WAYS,
  parameter int ID_BITS       = DEF_ID_BITS
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      req_valid,
  output logic           req_stall,
  input  wire cpst_req_t req,
  output logic           rsp_valid,
  input  wire logic      rsp_stall,
  output cpst_rsp_t      rsp
);

  localparam int NUM_BUCKETS = (TABLE_ENTRIES / BUCKET_WAYS) > 0 ?
                               (TABLE_ENTRIES / BUCKET_WAYS) : 1;
  localparam int LIVE_WAYS   = TABLE_ENTRIES < BUCKET_WAYS ? TABLE_ENTRIES : BUCKET_WAYS;
  localparam int BKT_W       = NUM_BUCKETS > 1 ? $clog2(NUM_BUCKETS) : 1;
  localparam int WAY_W       = LIVE_WAYS > 1 ? $clog2(LIVE_WAYS) : 1;
  localparam int SUM_W       = ID_BITS + 1;
  localparam bit BKT_POW2    = (NUM_BUCKETS & (NUM_BUCKETS - 1)) == 0;

  // remainder of the id sum, one 16-bit digit at a time from the top
  localparam int DIG_W    = 16;
  localparam int N_DIG    = (SUM_W + DIG_W - 1) / DIG_W;
  localparam int SUM_P    = N_DIG * DIG_W;
  localparam int CNT_W    = N_DIG > 1 ? $clog2(N_DIG) : 1;
  localparam int REM_W    = BKT_W + DIG_W;
  localparam int RECIP_W  = REM_W + 1;
  localparam int PROD_W   = REM_W + RECIP_W;
  localparam int RECIP_SH = REM_W + BKT_W;
  localparam logic [63:0] RECIP64 =
    ((64'd1 << RECIP_SH) + 64'(NUM_BUCKETS) - 64'd1) / 64'(NUM_BUCKETS);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP64);

  // entry layout: valid, first id, second id, contact state
  localparam int FIRST_LO  = 1;
  localparam int SECOND_LO = 1 + ID_BITS;
  localparam int ST_LO     = 1 + 2 * ID_BITS;
  localparam int ENT_W     = ST_LO + 3;
  localparam int ROW_W     = LIVE_WAYS * ENT_W;

  cpst_fsm_t state, state_next;

  logic [ROW_W-1:0] mem [NUM_BUCKETS];
  logic [ROW_W-1:0] rd_row;

  logic [BKT_W-1:0]   clr_idx;
  logic [BKT_W-1:0]   bkt;
  logic [SUM_P-1:0]   sum_sh;
  logic [CNT_W-1:0]   cnt;
  logic               rem_phase;
  logic [DIG_W-1:0]   quot;
  logic [1:0]         mode;
  logic [ID_BITS-1:0] id_a;
  logic [ID_BITS-1:0] id_b;
  logic               was_colliding;

  logic               req_take;
  logic               clr_done;
  logic               hash_done;
  logic               out_go;
  logic               rd_en;
  logic               mem_we;
  logic [BKT_W-1:0]   mem_waddr;
  logic [ROW_W-1:0]   mem_wdata;
  logic               rsp_load;

  logic               hit;
  logic               free;
  logic [WAY_W-1:0]   hit_way;
  logic [WAY_W-1:0]   free_way;
  logic [2:0]         hit_st;
  logic [2:0]         new_st;
  logic [ROW_W-1:0]   upd_row;
  cpst_rsp_t          rsp_next;

  logic [ID_BITS-1:0] in_a;
  logic [ID_BITS-1:0] in_b;
  logic [REM_W-1:0]   rem_in;
  logic [PROD_W-1:0]  rem_prod;

  assign in_a = ID_BITS'(req.id_a);
  assign in_b = ID_BITS'(req.id_b);

  assign req_take  = req_valid && (state == S_IDLE);
  assign clr_done  = clr_idx == BKT_W'(NUM_BUCKETS - 1);
  assign hash_done = BKT_POW2 || (rem_phase && (cnt == CNT_W'(N_DIG - 1)));
  assign out_go    = !rsp_valid || !rsp_stall;
  assign rem_in    = {bkt, sum_sh[SUM_P-1 -: DIG_W]};
  assign rem_prod  = PROD_W'(rem_in) * PROD_W'(RECIP);

  // search the bucket row, lowest way wins
  always_comb begin
    hit      = 1'b0;
    free     = 1'b0;
    hit_way  = '0;
    free_way = '0;
    hit_st   = PST_NONE;
    for (int w = 0; w < LIVE_WAYS; w++) begin
      if (rd_row[w*ENT_W]) begin
        if (!hit &&
            ((rd_row[w*ENT_W+FIRST_LO +: ID_BITS] == id_a &&
              rd_row[w*ENT_W+SECOND_LO +: ID_BITS] == id_b) ||
             (rd_row[w*ENT_W+FIRST_LO +: ID_BITS] == id_b &&
              rd_row[w*ENT_W+SECOND_LO +: ID_BITS] == id_a))) begin
          hit     = 1'b1;
          hit_way = WAY_W'(w);
          hit_st  = rd_row[w*ENT_W+ST_LO +: 3];
        end
      end else if (!free) begin
        free     = 1'b1;
        free_way = WAY_W'(w);
      end
    end
  end

  assign new_st = cpst_new_state(mode, was_colliding);

  always_comb begin
    upd_row = rd_row;
    for (int w = 0; w < LIVE_WAYS; w++) begin
      if (hit) begin
        if (hit_way == WAY_W'(w)) begin
          upd_row[w*ENT_W+ST_LO +: 3] = new_st;
        end
      end else if (free && free_way == WAY_W'(w)) begin
        upd_row[w*ENT_W +: ENT_W] = {new_st, id_b, id_a, 1'b1};
      end
    end
  end

  always_comb begin
    if (mode == MODE_QUERY) begin
      rsp_next.pair_state = hit ? hit_st : PST_NONE;
      rsp_next.found      = hit;
      rsp_next.table_full = 1'b0;
    end else begin
      rsp_next.pair_state = new_st;
      rsp_next.found      = hit;
      rsp_next.table_full = !hit && !free;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR:  if (clr_done) state_next = S_IDLE;
      S_IDLE:   if (req_valid) state_next = S_HASH;
      S_HASH:   if (hash_done) state_next = S_READ;
      S_READ:   state_next = S_UPDATE;
      S_UPDATE: if (out_go) state_next = S_IDLE;
      default:  state_next = S_CLEAR;
    endcase
  end

  // control outputs
  always_comb begin
    req_stall = 1'b1;
    rd_en     = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = bkt;
    mem_wdata = upd_row;
    rsp_load  = 1'b0;
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx;
        mem_wdata = '0;
      end
      S_IDLE: begin
        req_stall = 1'b0;
      end
      S_HASH: begin
      end
      S_READ: begin
        rd_en = 1'b1;
      end
      S_UPDATE: begin
        rsp_load = out_go;
        mem_we   = out_go && (mode != MODE_QUERY) && (hit || free);
      end
      default: begin
      end
    endcase
  end

  // table memory, whole bucket row per access
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_row <= mem[bkt];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_idx <= clr_idx + BKT_W'(1);
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // request capture and bucket index
  always_ff @(posedge clk) begin
    if (req_take) begin
      mode          <= req.mode;
      id_a          <= in_a;
      id_b          <= in_b;
      was_colliding <= req.was_colliding;
      sum_sh        <= SUM_P'(in_a) + SUM_P'(in_b);
      cnt           <= '0;
      rem_phase     <= 1'b0;
      bkt           <= '0;
    end else if (state == S_HASH) begin
      if (BKT_POW2) begin
        bkt <= sum_sh[BKT_W-1:0] & BKT_W'(NUM_BUCKETS - 1);
      end else if (!rem_phase) begin
        // quotient digit by reciprocal multiply, exact since rem_in < 2^REM_W
        quot      <= DIG_W'(rem_prod >> RECIP_SH);
        rem_phase <= 1'b1;
      end else begin
        bkt       <= BKT_W'(rem_in - REM_W'(quot) * REM_W'(NUM_BUCKETS));
        sum_sh    <= sum_sh << DIG_W;
        cnt       <= cnt + CNT_W'(1);
        rem_phase <= 1'b0;
      end
    end
    if (rsp_load) begin
      rsp <= rsp_next;
    end
  end

endmodule

`default_nettype wire
